FILE: hw/rtl/srcs_pkg.sv
// Shared types and codes for the compressed-row sparse matrix store.
package srcs_pkg;

	localparam logic [2:0] ST_INSERTED    = 3'd0;
	localparam logic [2:0] ST_OVERWRITTEN = 3'd1;
	localparam logic [2:0] ST_ENTRY       = 3'd2;
	localparam logic [2:0] ST_EMPTY       = 3'd3;
	localparam logic [2:0] ST_BAD         = 3'd4;
	localparam logic [2:0] ST_FULL        = 3'd5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	localparam logic CFG_NUM_ROWS = 1'b0;
	localparam logic CFG_NUM_COLS = 1'b1;

	localparam logic [6:0] NUM_RESET = 7'd64;
	localparam int ENTRY_W = 38;

	typedef struct packed {
		logic               opcode;
		logic [5:0]         target_row;
		logic [5:0]         target_col;
		logic signed [31:0] new_value;
	} in_word_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [5:0]         out_col;
		logic signed [31:0] out_value;
		logic               last;
	} out_word_t;

	typedef struct packed {
		logic [5:0]  col;
		logic [31:0] value;
	} entry_t;

	typedef struct packed {
		logic       load;
		logic       clr;
		logic       rd_lo;
		logic       rd_hi;
		logic       cap_lo;
		logic       cap_hi;
		logic       clamp;
		logic       ent_rd;
		logic       pos_inc;
		logic       ovr_wr;
		logic       sh_start;
		logic       sh_step;
		logic       new_wr;
		logic       pu_start;
		logic       pu_step;
		logic       emit;
		logic       emit_ent;
		logic [2:0] code;
	} cmd_t;

	typedef struct packed {
		logic opcode;
		logic row_bad;
		logic col_bad;
		logic clr_done;
		logic empty;
		logic pos_lt_end;
		logic col_lt;
		logic col_eq;
		logic full;
		logic cnt_gt_pos;
		logic k_gt_pos;
		logic pu_done;
		logic out_free;
		logic ent_last;
	} stat_t;

endpackage

FILE: hw/rtl/srcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: hw/rtl/srcs_ctrl.sv
// Sequencer taking each word via lookup, scan, shift, pointer update or read.
module srcs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  srcs_pkg::stat_t st,
	output srcs_pkg::cmd_t  cmd
);
	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_P0, S_P1, S_P2, S_P3, S_DISP,
		S_SC_ISSUE, S_SC_CHK, S_NOTF, S_SH_START, S_SH_RUN, S_NEW,
		S_PU_START, S_PU_RUN, S_RD_ISSUE, S_RD_EMIT, S_RESP
	} state_t;

	state_t     state_q;
	logic [2:0] code_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.code = code_q;
		case (state_q)
			S_CLR:      cmd.clr = 1'b1;
			S_IDLE:     cmd.load = in_valid;
			S_P0:       cmd.rd_lo = !st.row_bad;
			S_P1: begin
				cmd.rd_hi  = 1'b1;
				cmd.cap_lo = 1'b1;
			end
			S_P2:       cmd.cap_hi = 1'b1;
			S_P3:       cmd.clamp = 1'b1;
			S_SC_ISSUE: cmd.ent_rd = st.pos_lt_end;
			S_SC_CHK: begin
				cmd.pos_inc = st.col_lt;
				cmd.ovr_wr  = st.col_eq;
			end
			S_SH_START: cmd.sh_start = 1'b1;
			S_SH_RUN:   cmd.sh_step = 1'b1;
			S_NEW:      cmd.new_wr = 1'b1;
			S_PU_START: cmd.pu_start = 1'b1;
			S_PU_RUN:   cmd.pu_step = 1'b1;
			S_RD_ISSUE: cmd.ent_rd = 1'b1;
			S_RD_EMIT: begin
				cmd.emit     = st.out_free;
				cmd.emit_ent = 1'b1;
				cmd.pos_inc  = st.out_free;
			end
			S_RESP:     cmd.emit = st.out_free;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			code_q  <= srcs_pkg::ST_BAD;
		end else begin
			case (state_q)
				S_CLR:  if (st.clr_done) state_q <= S_IDLE;
				S_IDLE: if (in_valid) state_q <= S_P0;
				S_P0: begin
					if (st.row_bad) begin
						code_q  <= srcs_pkg::ST_BAD;
						state_q <= S_RESP;
					end else begin
						state_q <= S_P1;
					end
				end
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_P3;
				S_P3: state_q <= S_DISP;
				S_DISP: begin
					if (st.opcode == srcs_pkg::OP_READ) begin
						if (st.empty) begin
							code_q  <= srcs_pkg::ST_EMPTY;
							state_q <= S_RESP;
						end else begin
							state_q <= S_RD_ISSUE;
						end
					end else if (st.col_bad) begin
						code_q  <= srcs_pkg::ST_BAD;
						state_q <= S_RESP;
					end else begin
						state_q <= S_SC_ISSUE;
					end
				end
				S_SC_ISSUE: state_q <= st.pos_lt_end ? S_SC_CHK : S_NOTF;
				S_SC_CHK: begin
					if (st.col_lt) begin
						state_q <= S_SC_ISSUE;
					end else if (st.col_eq) begin
						code_q  <= srcs_pkg::ST_OVERWRITTEN;
						state_q <= S_RESP;
					end else begin
						state_q <= S_NOTF;
					end
				end
				S_NOTF: begin
					if (st.full) begin
						code_q  <= srcs_pkg::ST_FULL;
						state_q <= S_RESP;
					end else begin
						state_q <= st.cnt_gt_pos ? S_SH_START : S_NEW;
					end
				end
				S_SH_START: state_q <= S_SH_RUN;
				S_SH_RUN:   if (!st.k_gt_pos) state_q <= S_NEW;
				S_NEW:      state_q <= S_PU_START;
				S_PU_START: state_q <= S_PU_RUN;
				S_PU_RUN: begin
					if (st.pu_done) begin
						code_q  <= srcs_pkg::ST_INSERTED;
						state_q <= S_RESP;
					end
				end
				S_RD_ISSUE: state_q <= S_RD_EMIT;
				S_RD_EMIT: begin
					if (st.out_free) state_q <= st.ent_last ? S_IDLE : S_RD_ISSUE;
				end
				S_RESP: if (st.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: hw/rtl/srcs_dp.sv
// Datapath: configuration, row pointers, entry store, counters and output register.
module srcs_dp #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int CAPACITY = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  srcs_pkg::in_word_t  in_data,
	input  logic                cfg_valid,
	input  logic                cfg_index,
	input  logic [6:0]          cfg_data,
	output srcs_pkg::out_word_t out_data,
	output logic                out_valid,
	input  logic                out_ready,
	input  srcs_pkg::cmd_t      cmd,
	output srcs_pkg::stat_t     st
);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int RW = $clog2(MAX_ROWS + 1);

	srcs_pkg::in_word_t  item_q;
	srcs_pkg::out_word_t out_q;
	srcs_pkg::entry_t    ent_rd, ent_wd;
	logic          out_valid_q;
	logic [6:0]    num_rows_q, num_cols_q;
	logic [CW-1:0] start_q, end_q, pos_q, k_q, count_q;
	logic [RW-1:0] r_q;
	logic [CW-1:0] ptr_rd, ptr_wd, pos_inc, k_inc, k_dec;
	logic [RW-1:0] ptr_ra, ptr_wa, row_a, row1_a, r_inc;
	logic [31:0]   row_w, col_w;
	logic          ptr_we, ptr_re, ent_we, ent_re;
	logic [AW-1:0] ent_wa, ent_ra;

	assign row_w   = {26'd0, item_q.target_row};
	assign col_w   = {26'd0, item_q.target_col};
	assign row_a   = row_w[RW-1:0];
	assign row1_a  = RW'(row_w + 32'd1);
	assign r_inc   = r_q + 1'b1;
	assign pos_inc = pos_q + 1'b1;
	assign k_inc   = k_q + 1'b1;
	assign k_dec   = k_q - 1'b1;

	// Row pointer store.
	always_comb begin
		ptr_we = cmd.clr | cmd.pu_step;
		ptr_wa = r_q;
		ptr_wd = cmd.clr ? '0 : ptr_rd + 1'b1;
		ptr_re = cmd.rd_lo | cmd.rd_hi | cmd.pu_start | (cmd.pu_step & !st.pu_done);
		ptr_ra = (cmd.rd_hi | cmd.pu_start) ? row1_a : (cmd.rd_lo ? row_a : r_inc);
	end

	srcs_ram #(.WIDTH(CW), .DEPTH(MAX_ROWS + 1)) u_ptr_ram (
		.clk(clk), .we(ptr_we), .waddr(ptr_wa), .wdata(ptr_wd),
		.re(ptr_re), .raddr(ptr_ra), .rdata(ptr_rd)
	);

	// Entry store: column and value side by side.
	always_comb begin
		ent_we = cmd.ovr_wr | cmd.new_wr | cmd.sh_step;
		ent_wa = cmd.sh_step ? k_inc[AW-1:0] : pos_q[AW-1:0];
		ent_wd = cmd.sh_step ? ent_rd : {item_q.target_col, item_q.new_value};
		ent_re = cmd.ent_rd | cmd.sh_start | (cmd.sh_step & st.k_gt_pos);
		ent_ra = cmd.ent_rd ? pos_q[AW-1:0] :
			(cmd.sh_start ? AW'(count_q - 1'b1) : k_dec[AW-1:0]);
	end

	srcs_ram #(.WIDTH(srcs_pkg::ENTRY_W), .DEPTH(CAPACITY)) u_ent_ram (
		.clk(clk), .we(ent_we), .waddr(ent_wa), .wdata(ent_wd),
		.re(ent_re), .raddr(ent_ra), .rdata(ent_rd)
	);

	always_comb begin
		st.opcode     = item_q.opcode;
		st.row_bad    = ({1'b0, item_q.target_row} >= num_rows_q) ||
			(row_w >= 32'(MAX_ROWS));
		st.col_bad    = ({1'b0, item_q.target_col} >= num_cols_q) ||
			(col_w >= 32'(MAX_COLS));
		st.clr_done   = (r_q == RW'(MAX_ROWS));
		st.empty      = (start_q == end_q);
		st.pos_lt_end = (pos_q < end_q);
		st.col_lt     = (ent_rd.col < item_q.target_col);
		st.col_eq     = (ent_rd.col == item_q.target_col);
		st.full       = (count_q >= CW'(CAPACITY));
		st.cnt_gt_pos = (count_q > pos_q);
		st.k_gt_pos   = (k_q > pos_q);
		st.pu_done    = (r_q == RW'(MAX_ROWS));
		st.out_free   = !out_valid_q || out_ready;
		st.ent_last   = (pos_inc == end_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q  <= srcs_pkg::NUM_RESET;
			num_cols_q  <= srcs_pkg::NUM_RESET;
			count_q     <= '0;
			r_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == srcs_pkg::CFG_NUM_ROWS) num_rows_q <= cfg_data;
				if (cfg_index == srcs_pkg::CFG_NUM_COLS) num_cols_q <= cfg_data;
			end
			if (cmd.new_wr) count_q <= count_q + 1'b1;
			if (cmd.clr) r_q <= r_inc;
			else if (cmd.pu_start) r_q <= row1_a;
			else if (cmd.pu_step && !st.pu_done) r_q <= r_inc;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_data;
		if (cmd.cap_lo) start_q <= ptr_rd;
		if (cmd.cap_hi) end_q <= (ptr_rd > count_q) ? count_q : ptr_rd;
		if (cmd.clamp) begin
			start_q <= (start_q > end_q) ? end_q : start_q;
			pos_q   <= (start_q > end_q) ? end_q : start_q;
		end else if (cmd.pos_inc) begin
			pos_q <= pos_inc;
		end
		if (cmd.sh_start) k_q <= count_q - 1'b1;
		else if (cmd.sh_step && st.k_gt_pos) k_q <= k_dec;
		if (cmd.emit) begin
			if (cmd.emit_ent) begin
				out_q.status    <= srcs_pkg::ST_ENTRY;
				out_q.out_col   <= ent_rd.col;
				out_q.out_value <= ent_rd.value;
				out_q.last      <= st.ent_last;
			end else begin
				out_q.status    <= cmd.code;
				out_q.out_col   <= '0;
				out_q.out_value <= '0;
				out_q.last      <= 1'b1;
			end
		end
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result word overwritten before taken");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.clamp) |-> (start_q <= end_q && pos_q == start_q))
		else $error("row bounds out of order after clamp");
	a_shift_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sh_start |-> (count_q < CW'(CAPACITY) && count_q > pos_q))
		else $error("shift started without room");
`endif
endmodule

FILE: hw/rtl/sparse_row_compressed_store_top.sv
// Top level of the compressed-row sparse matrix store.
// A bad row answers after the row check; lookup reads and captures the row's two pointers
// and clamps them, then scans the row's entries one at a time. Insert shifts each later
// entry up through the entry RAM port, then steps each later row pointer up through the pointer RAM port.
// Read emits one word per row entry, holding while the output word is not taken; one word
// in flight, items are handled one at a time. Reset clears control at once, then zeroes
// row pointers 0 to MAX_ROWS with in_ready low; configuration writes are taken throughout.
module sparse_row_compressed_store_top #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int CAPACITY = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  srcs_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output srcs_pkg::out_word_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [6:0]          cfg_data
);
	srcs_pkg::cmd_t  cmd;
	srcs_pkg::stat_t st;

	// Configuration is always taken; writes must come only while idle, which the block does not enforce.
	assign cfg_ready = 1'b1;

	// Sequence each word through its steps.
	srcs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.st(st), .cmd(cmd)
	);

	// Hold stores, counters and the output word.
	srcs_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .CAPACITY(CAPACITY)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_data),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_data(out_data), .out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .st(st)
	);
endmodule

FILE: tb/tb_sparse_row_compressed_store_top.sv
// Self-checking testbench for the compressed-row sparse matrix store top level.
module tb_sparse_row_compressed_store_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int CAPACITY = 1024;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic       index;
		logic [6:0] data;
	} reg_write_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	srcs_pkg::in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	srcs_pkg::out_word_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_index = 1'b0;
	logic [6:0] cfg_data = '0;

	// Mirror of the matrix store and registers
	logic [31:0] ent_val [CAPACITY];
	logic [5:0]  ent_col [CAPACITY];
	int          row_ptr [MAX_ROWS+1];
	int          ent_cnt = 0;
	int          rows_reg = 64;
	int          cols_reg = 64;

	srcs_pkg::in_word_t  pending_words[$];
	reg_write_t          pending_regs[$];
	srcs_pkg::out_word_t expected_words[$];

	bit fail_seen = 0;
	bit calm = 0;
	int in_gap = 0;
	int out_gap = 0;
	int quiet_cycles = 0;

	sparse_row_compressed_store_top #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS),
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Append helpers for the item, register and result queues.
	task automatic queue_result(srcs_pkg::out_word_t r);
		expected_words = {expected_words, r};
	endtask

	task automatic queue_item(srcs_pkg::in_word_t w);
		pending_words = {pending_words, w};
	endtask

	task automatic queue_reg(logic idx, logic [6:0] d);
		reg_write_t rw;
		rw.index = idx;
		rw.data = d;
		pending_regs = {pending_regs, rw};
	endtask

	// Work out the result words one accepted item causes and advance the mirror.
	task automatic apply_item(srcs_pkg::in_word_t w);
		int rb, cb, s, e, p, k;
		srcs_pkg::out_word_t r;
		rb = (rows_reg < MAX_ROWS) ? rows_reg : MAX_ROWS;
		cb = (cols_reg < MAX_COLS) ? cols_reg : MAX_COLS;
		r = '0;
		r.last = 1'b1;
		if (int'(w.target_row) >= rb) begin
			r.status = srcs_pkg::ST_BAD;
			queue_result(r);
			return;
		end
		s = row_ptr[w.target_row];
		e = row_ptr[w.target_row + 1];
		if (e > ent_cnt) e = ent_cnt;
		if (s > e) s = e;
		if (w.opcode == srcs_pkg::OP_READ) begin
			if (s == e) begin
				r.status = srcs_pkg::ST_EMPTY;
				queue_result(r);
				return;
			end
			for (p = s; p < e && p - s < 64; p++) begin
				r.status = srcs_pkg::ST_ENTRY;
				r.out_col = ent_col[p];
				r.out_value = ent_val[p];
				r.last = (p == e - 1 || p - s == 63);
				queue_result(r);
			end
			return;
		end
		if (int'(w.target_col) >= cb) begin
			r.status = srcs_pkg::ST_BAD;
			queue_result(r);
			return;
		end
		p = s;
		while (p < e && ent_col[p] < w.target_col) p++;
		if (p < e && ent_col[p] == w.target_col) begin
			ent_val[p] = w.new_value;
			r.status = srcs_pkg::ST_OVERWRITTEN;
			queue_result(r);
			return;
		end
		if (ent_cnt >= CAPACITY) begin
			r.status = srcs_pkg::ST_FULL;
			queue_result(r);
			return;
		end
		for (k = ent_cnt; k > p; k--) begin
			ent_val[k] = ent_val[k-1];
			ent_col[k] = ent_col[k-1];
		end
		ent_val[p] = w.new_value;
		ent_col[p] = w.target_col;
		ent_cnt++;
		for (k = w.target_row + 1; k <= MAX_ROWS; k++) row_ptr[k]++;
		r.status = srcs_pkg::ST_INSERTED;
		queue_result(r);
	endtask

	// Item driver: hold a word until it is taken, idle in random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready) apply_item(in_data);
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					in_gap = $urandom_range(0, 11);
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= pending_words.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Register write driver: update the mirror when the write is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_index <= 1'b0;
			cfg_data <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == srcs_pkg::CFG_NUM_ROWS) rows_reg = int'(cfg_data);
				else cols_reg = int'(cfg_data);
			end
			if (!cfg_valid || cfg_ready) begin
				if (pending_regs.size() > 0) begin
					reg_write_t rw;
					rw = pending_regs.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= rw.index;
					cfg_data <= rw.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: stall in random bursts, check each taken word in order.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word %h", $time, out_data);
					fail_seen = 1;
				end else begin
					srcs_pkg::out_word_t x;
					x = expected_words.pop_front();
					if (x.status !== out_data.status || x.out_col !== out_data.out_col ||
					    x.out_value !== out_data.out_value || x.last !== out_data.last) begin
						$display("%0t: expected st=%0d col=%0d val=%h last=%0d,",
							$time, x.status, x.out_col, x.out_value, x.last);
						$display("  got st=%0d col=%0d val=%h last=%0d",
							out_data.status, out_data.out_col, out_data.out_value,
							out_data.last);
						fail_seen = 1;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				out_gap = $urandom_range(0, 11);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	function automatic srcs_pkg::in_word_t mk_item(logic op, int r, int c, logic [31:0] v);
		srcs_pkg::in_word_t w;
		w.opcode = op;
		w.target_row = 6'(r);
		w.target_col = 6'(c);
		w.new_value = v;
		return w;
	endfunction

	task automatic set_regs(int rows, int cols);
		queue_reg(srcs_pkg::CFG_NUM_ROWS, 7'(rows));
		queue_reg(srcs_pkg::CFG_NUM_COLS, 7'(cols));
	endtask

	// Wait for every queued word and result, then let the block settle.
	task automatic drain();
		while (pending_words.size() != 0 || in_valid || pending_regs.size() != 0 ||
		       cfg_valid || expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Random items: mostly a few busy rows within the bound, some anywhere.
	task automatic random_items(int n);
		int i, rb, r;
		rb = (rows_reg < MAX_ROWS) ? rows_reg : MAX_ROWS;
		for (i = 0; i < n; i++) begin
			if (rb > 0 && $urandom_range(0, 3) != 0)
				r = $urandom_range(0, (rb < 4 ? rb : 4) - 1);
			else
				r = $urandom_range(0, 63);
			queue_item(mk_item(($urandom_range(0, 9) < 3) ?
				srcs_pkg::OP_READ : srcs_pkg::OP_INSERT,
				r, $urandom_range(0, 63), $urandom));
		end
	endtask

	initial begin
		int i, r, c;
		for (i = 0; i <= MAX_ROWS; i++) row_ptr[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: value extremes, ordering, overwrite, empty rows, edge rows.
		set_regs(64, 64);
		drain();
		queue_item(mk_item(srcs_pkg::OP_READ, 0, 0, 0));
		queue_item(mk_item(srcs_pkg::OP_INSERT, 0, 0, 32'h7fffffff));
		queue_item(mk_item(srcs_pkg::OP_INSERT, 0, 63, 32'h80000000));
		queue_item(mk_item(srcs_pkg::OP_INSERT, 0, 5, 32'h1));
		queue_item(mk_item(srcs_pkg::OP_INSERT, 0, 5, 32'hffffffff));
		queue_item(mk_item(srcs_pkg::OP_READ, 0, 63, 32'hffffffff));
		queue_item(mk_item(srcs_pkg::OP_INSERT, 63, 63, 32'h55555555));
		queue_item(mk_item(srcs_pkg::OP_INSERT, 63, 0, 32'haaaaaaaa));
		queue_item(mk_item(srcs_pkg::OP_READ, 63, 0, 0));
		queue_item(mk_item(srcs_pkg::OP_READ, 62, 0, 0));
		queue_item(mk_item(srcs_pkg::OP_INSERT, 2, 42, 32'h0));
		queue_item(mk_item(srcs_pkg::OP_READ, 1, 0, 0));
		drain();

		// Tight bounds: bad row, bad column, entries past the bound still read.
		set_regs(1, 1);
		drain();
		queue_item(mk_item(srcs_pkg::OP_INSERT, 0, 0, 32'h12345678));
		queue_item(mk_item(srcs_pkg::OP_INSERT, 0, 1, 32'h1));
		queue_item(mk_item(srcs_pkg::OP_INSERT, 1, 0, 32'h1));
		queue_item(mk_item(srcs_pkg::OP_READ, 1, 0, 0));
		queue_item(mk_item(srcs_pkg::OP_READ, 0, 0, 0));
		drain();

		// Zero rows: every index is bad.
		set_regs(0, 0);
		drain();
		queue_item(mk_item(srcs_pkg::OP_READ, 0, 0, 0));
		queue_item(mk_item(srcs_pkg::OP_INSERT, 0, 0, 32'h1));
		drain();

		// Registers above the maximum clamp to it.
		set_regs(127, 127);
		drain();
		random_items(60);
		drain();

		for (i = 0; i < 3; i++) begin
			set_regs($urandom_range(1, 64), $urandom_range(1, 64));
			drain();
			random_items(25);
			drain();
		end

		// Fill a few rows back to back without idling, then read and overwrite.
		calm = 1;
		set_regs(64, 64);
		drain();
		for (i = 0; i < 20; i++) begin
			r = i / 8;
			c = i % 8;
			queue_item(mk_item(srcs_pkg::OP_INSERT, r, c, $urandom));
		end
		queue_item(mk_item(srcs_pkg::OP_READ, 0, 0, 0));
		queue_item(mk_item(srcs_pkg::OP_READ, 17, 0, 0));
		queue_item(mk_item(srcs_pkg::OP_INSERT, 40, 3, 32'h1));
		queue_item(mk_item(srcs_pkg::OP_INSERT, 0, 0, 32'hdeadbeef));
		queue_item(mk_item(srcs_pkg::OP_READ, 0, 0, 0));
		drain();

		if (!fail_seen)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
